@@ rtl/sls8_pkg.sv @@
// Shared types and constants for the sync/length/sum8 deframer.
// No dependencies; compiled first.
package sls8_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] count_t;

  localparam byte_t SYNC_FIRST       = 8'hA5;
  localparam byte_t SYNC_SECOND      = 8'h5A;
  localparam byte_t MAX_LENGTH_RESET = 8'd251;

  // Front-to-back queue sizing
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADSUM  = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT1  = 2'd0,
    PH_HUNT2  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  // One classified transaction handed from front to back
  typedef struct packed {
    kind_t kind;
    byte_t data;
    byte_t position;
  } cmd_t;

endpackage

@@ rtl/sls8_rx_if.sv @@
// Received-byte channel: valid/ready handshake carrying rx_byte.
// Depends on sls8_pkg.
interface sls8_rx_if;
  logic              valid;
  logic              ready;
  sls8_pkg::byte_t   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sls8_res_if.sv @@
// Result channel: valid/ready handshake carrying kind, data, position, good_frames.
// Depends on sls8_pkg.
interface sls8_res_if;
  logic              valid;
  logic              ready;
  sls8_pkg::kind_t   kind;
  sls8_pkg::byte_t   data;
  sls8_pkg::byte_t   position;
  sls8_pkg::count_t  good_frames;

  modport source (output valid, output kind, output data, output position,
                  output good_frames, input ready);
  modport sink   (input valid, input kind, input data, input position,
                  input good_frames, output ready);
endinterface

@@ rtl/sync_length_sum8_deframer_top.sv @@
// Top level of the two-byte-sync, length-prefixed, sum8-checked deframer.
// Depends on sls8_pkg, sls8_rx_if, sls8_res_if, sls8_front, sls8_queue, sls8_back.
//
// Takes one received byte per transaction on rx and hunts for the sync pair
// A5 5A, then a length byte and that many payload bytes, then a checksum
// byte equal to the 8-bit wrapping sum of length and payload. Each payload
// byte comes out as a kind-0 result with its index; the checksum byte gives
// kind 1 (accepted, counted in good_frames) or kind 2 (mismatch); a length
// above max_length gives kind 3 and the hunt restarts. Sync and length
// bytes give no result. A byte is taken every cycle while the result side
// keeps up: the front end classifies it and updates its sync/length/sum state,
// then a two-entry queue and a registered result stage hold its result. rx.ready
// drops only when that queue is full, i.e. after the result side has stalled
// for two results. max_length (reset 251) is written through cfg_we/cfg_data;
// the user must write it only while idle, which the block does not enforce.
module sync_length_sum8_deframer_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  sls8_pkg::byte_t cfg_data,
  sls8_rx_if.sink         rx,
  sls8_res_if.source      result
);
  import sls8_pkg::*;

  byte_t max_length;
  logic  accept;
  logic  push;
  cmd_t  push_cmd;
  logic  pop;
  cmd_t  head;
  logic  q_full;
  logic  q_empty;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_data;
    end
  end

  // bytes flow while there is room for a possible result
  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;

  sls8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx.rx_byte),
    .max_length (max_length),
    .push       (push),
    .cmd        (push_cmd)
  );

  sls8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sls8_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ rtl/sls8_front.sv @@
// Front end: sync hunt, length check, running sum; emits classified transactions.
// Depends on sls8_pkg.
module sls8_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  sls8_pkg::byte_t rx_byte,
  input  sls8_pkg::byte_t max_length,
  output logic            push,
  output sls8_pkg::cmd_t  cmd
);
  import sls8_pkg::*;

  phase_t phase, phase_next;
  byte_t  payload_length, payload_length_next;
  byte_t  bytes_seen, bytes_seen_next;
  byte_t  running_sum, running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT1;
      payload_length <= '0;
      bytes_seen     <= '0;
      running_sum    <= '0;
    end else begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      running_sum    <= running_sum_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    running_sum_next    = running_sum;
    push                = 1'b0;
    cmd.kind            = KIND_PAYLOAD;
    cmd.data            = rx_byte;
    cmd.position        = bytes_seen;
    if (accept) begin
      case (phase)
        PH_HUNT1: begin
          if (rx_byte == SYNC_FIRST) phase_next = PH_HUNT2;
        end
        PH_HUNT2: begin
          // bad second byte drops straight back, not retested
          phase_next = (rx_byte == SYNC_SECOND) ? PH_LENGTH : PH_HUNT1;
        end
        PH_LENGTH: begin
          if (rx_byte > max_length) begin
            phase_next   = PH_HUNT1;
            push         = 1'b1;
            cmd.kind     = KIND_TOOLONG;
            cmd.position = rx_byte;
          end else begin
            payload_length_next = rx_byte;
            bytes_seen_next     = '0;
            running_sum_next    = rx_byte;
            phase_next          = PH_BODY;
          end
        end
        PH_BODY: begin
          push = 1'b1;
          if (bytes_seen < payload_length) begin
            running_sum_next = running_sum + rx_byte;
            bytes_seen_next  = bytes_seen + 8'd1;
          end else begin
            phase_next   = PH_HUNT1;
            cmd.kind     = (rx_byte == running_sum) ? KIND_GOOD : KIND_BADSUM;
            cmd.position = payload_length;
          end
        end
        default: phase_next = PH_HUNT1;
      endcase
    end
  end

endmodule

@@ rtl/sls8_queue.sv @@
// Short register queue decoupling the front end from the back end.
// Depends on sls8_pkg.
module sls8_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sls8_pkg::cmd_t push_cmd,
  input  logic           pop,
  output sls8_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import sls8_pkg::*;

  cmd_t            entry [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] count;

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + Q_CW'(1);
      else if (pop && !push) count <= count - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

  assign head  = entry[rd_ptr];
  assign full  = (count == Q_CW'(Q_DEPTH));
  assign empty = (count == '0);

  a_no_push_full:  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_pop_empty:  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");
  a_push_fills:    assert property (@(posedge clk) disable iff (rst)
                     (push && !pop) |=> !empty)
    else $error("pushed transaction lost");
  a_count_bound:   assert property (@(posedge clk) disable iff (rst)
                     count <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/sls8_back.sv @@
// Back end: good-frame counter and registered result stage.
// Depends on sls8_pkg and sls8_res_if.
module sls8_back (
  input  logic           clk,
  input  logic           rst,
  input  sls8_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  sls8_res_if.source     result
);
  import sls8_pkg::*;

  count_t good_count, good_count_next;
  logic   out_valid;
  kind_t  out_kind;
  byte_t  out_data;
  byte_t  out_position;
  count_t out_good;
  logic   load;

  assign load = !out_valid || result.ready;
  assign pop  = load && !empty;
  assign good_count_next = (head.kind == KIND_GOOD) ? good_count + 32'd1 : good_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      good_count <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (pop) good_count <= good_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind     <= head.kind;
      out_data     <= head.data;
      out_position <= head.position;
      out_good     <= good_count_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.data        = out_data;
  assign result.position    = out_position;
  assign result.good_frames = out_good;

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
                    (pop && head.kind == KIND_GOOD) |=> (good_count == $past(good_count) + 32'd1))
    else $error("good-frame count missed an accepted frame");
  a_count_holds:  assert property (@(posedge clk) disable iff (rst)
                    !(pop && head.kind == KIND_GOOD) |=> $stable(good_count))
    else $error("good-frame count moved without an accepted frame");
  a_stall_holds:  assert property (@(posedge clk) disable iff (rst)
                    (out_valid && !result.ready) |-> !pop)
    else $error("result overwritten while stalled");

endmodule
